>>> hw/rtl/key_ordered_process_queue_macros.svh
// ============================================================================
// Assertion macros for the key-ordered process queue
// Concurrent checks clocked on clk, held off while rst_n is low.
// ============================================================================
`ifndef KEY_ORDERED_PROCESS_QUEUE_MACROS_SVH
`define KEY_ORDERED_PROCESS_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define KOPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KOPQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KOPQ_ASSERT_IMP(label, ante, cons, msg)
`define KOPQ_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

>>> hw/rtl/kopq_pkg.sv
// ============================================================================
// kopq_pkg
// Shared types and constants of the key-ordered process queue.
// ============================================================================
package kopq_pkg;

    localparam int QUEUE_DEPTH_DEF = 128;
    localparam int ID_LIMIT_DEF    = 103;

    localparam int ID_W     = 7;
    localparam int KEY_W    = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    localparam int S_DATA_W = 40;   // id + key, padded to bytes
    localparam int M_DATA_W = 88;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_INSERT = 2'd2
    } func_t;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic        [ID_W-1:0]  id;
        logic signed [KEY_W-1:0] key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SR_RD,
        S_SR_CMP,
        S_SH_RD,
        S_SH_WR,
        S_INS_WR,
        S_RM_TAKE,
        S_FR_RD,
        S_FR_TAKE,
        S_BK_TAKE,
        S_DONE
    } state_t;

endpackage

>>> hw/rtl/kopq_entry_ram.sv
// ============================================================================
// kopq_entry_ram
// Entry store: one write port, one read port, registered read data.
// ============================================================================
module kopq_entry_ram #(
    parameter int DEPTH = kopq_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH = kopq_pkg::ENTRY_W
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/key_ordered_process_queue.sv
// ============================================================================
// key_ordered_process_queue
// Scheduler process queue: append, remove front, and key-ordered insert.
// ============================================================================
// Holds up to QUEUE_DEPTH (id, key) entries in a circular buffer in one
// single-port-read / single-port-write RAM; a head pointer and an entry count
// give the logical order, so a remove never moves data. Each transaction on
// the slave side carries one operation in tuser; the block drops tready while
// it works and returns exactly one result transaction on the master side.
// Timing is set by the RAM read port, one read a cycle with registered data.
// Every operation ends by reading the front and back entries for the
// result, a step that is skipped when the queue is then empty. An ordered
// insert first searches, reading entries front to back up to the landing
// place, then moves the tail back one entry at a time, then writes the new
// entry. A stalled result waits in the output register; a new transaction
// is taken meanwhile and its result waits behind it. The RAM needs no clear
// after reset: only entries below the count are ever read.
`include "key_ordered_process_queue_macros.svh"

module key_ordered_process_queue #(
    parameter int QUEUE_DEPTH = kopq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_LIMIT    = kopq_pkg::ID_LIMIT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave side
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [6:0] proc_id, [38:7] prio_key, [39] zero pad
    input  logic [kopq_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [1:0] func
    input  logic [kopq_pkg::FUNC_W-1:0]   s_axis_tuser,
    // master side
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [1:0] status, [8:2] removed_id, [9] empty_flag, [16:10] front_id,
    // [23:17] back_id, [55:24] front_key, [87:56] back_key
    output logic [kopq_pkg::M_DATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W  = kopq_pkg::ID_W;
    localparam int KEY_W = kopq_pkg::KEY_W;

    kopq_pkg::state_t state_reg, state_next;

    logic [ID_W-1:0]              id_reg, id_next;
    logic signed [KEY_W-1:0]      key_reg, key_next;
    logic [kopq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]              removed_reg, removed_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [IDX_W-1:0]             head_reg, head_next;
    logic [CNT_W-1:0]             idx_reg, idx_next;
    logic [CNT_W-1:0]             pos_reg, pos_next;
    kopq_pkg::entry_t             front_reg, front_next;
    kopq_pkg::entry_t             back_reg, back_next;
    logic                         out_valid_reg, out_valid_next;
    logic [kopq_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;

    // RAM port signals
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    kopq_pkg::entry_t             wr_entry;
    logic                         rd_en;
    logic [IDX_W-1:0]             rd_addr;
    logic [kopq_pkg::ENTRY_W-1:0] rd_data;
    kopq_pkg::entry_t             rd_entry;

    // incoming fields
    logic [ID_W-1:0]         in_id;
    logic signed [KEY_W-1:0] in_key;
    logic                    is_full;
    logic                    is_empty;

    assign in_id    = s_axis_tdata[ID_W-1:0];
    assign in_key   = s_axis_tdata[ID_W+KEY_W-1:ID_W];
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);
    assign rd_entry = kopq_pkg::entry_t'(rd_data);

    // logical position -> RAM address; sum stays below twice the depth
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] lidx);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W+1-IDX_W){1'b0}}, head} + {1'b0, lidx};
        if (sum >= (CNT_W+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    kopq_entry_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (kopq_pkg::ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == kopq_pkg::S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kopq_pkg::S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and scratch registers
    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
        removed_reg  <= removed_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        front_reg    <= front_next;
        back_reg     <= back_next;
        out_data_reg <= out_data_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        id_next        = id_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        wr_en          = 1'b0;
        wr_addr        = phys(head_reg, count_reg);
        wr_entry       = '{id: id_reg, key: key_reg};
        rd_en          = 1'b0;
        rd_addr        = phys(head_reg, idx_reg);

        case (state_reg)
            kopq_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    id_next      = in_id;
                    key_next     = in_key;
                    status_next  = kopq_pkg::ST_OK;
                    removed_next = '0;
                    state_next   = kopq_pkg::S_FR_RD;
                    case (kopq_pkg::func_t'(s_axis_tuser))
                        kopq_pkg::FUNC_APPEND:
                        begin
                            if (is_full)
                            begin
                                status_next = kopq_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = phys(head_reg, count_reg);
                                wr_entry   = '{id: in_id, key: in_key};
                                count_next = count_reg + 1'b1;
                            end
                        end
                        kopq_pkg::FUNC_REMOVE:
                        begin
                            if (is_empty)
                            begin
                                status_next = kopq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                state_next = kopq_pkg::S_RM_TAKE;
                            end
                        end
                        kopq_pkg::FUNC_INSERT:
                        begin
                            if (in_id >= ID_W'(ID_LIMIT))
                            begin
                                status_next = kopq_pkg::ST_BADID;
                            end
                            else if (is_full)
                            begin
                                status_next = kopq_pkg::ST_FULL;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = kopq_pkg::S_SR_RD;
                            end
                        end
                        default:
                        begin
                            status_next = kopq_pkg::ST_OK;
                        end
                    endcase
                end
            end

            // walk front to back until an entry's key drops below the new key
            kopq_pkg::S_SR_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    pos_next   = count_reg;
                    idx_next   = count_reg;
                    state_next = kopq_pkg::S_SH_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = phys(head_reg, idx_reg);
                    state_next = kopq_pkg::S_SR_CMP;
                end
            end

            kopq_pkg::S_SR_CMP:
            begin
                if ($signed(rd_entry.key) >= $signed(key_reg))
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = kopq_pkg::S_SR_RD;
                end
                else
                begin
                    pos_next   = idx_reg;
                    idx_next   = count_reg;
                    state_next = kopq_pkg::S_SH_RD;
                end
            end

            // move the tail back one slot, last entry first
            kopq_pkg::S_SH_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    state_next = kopq_pkg::S_INS_WR;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = phys(head_reg, idx_reg - 1'b1);
                    state_next = kopq_pkg::S_SH_WR;
                end
            end

            kopq_pkg::S_SH_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = phys(head_reg, idx_reg);
                wr_entry   = rd_entry;
                idx_next   = idx_reg - 1'b1;
                state_next = kopq_pkg::S_SH_RD;
            end

            kopq_pkg::S_INS_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = phys(head_reg, pos_reg);
                wr_entry   = '{id: id_reg, key: key_reg};
                count_next = count_reg + 1'b1;
                state_next = kopq_pkg::S_FR_RD;
            end

            kopq_pkg::S_RM_TAKE:
            begin
                removed_next = rd_entry.id;
                head_next    = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : head_reg + 1'b1;
                count_next   = count_reg - 1'b1;
                state_next   = kopq_pkg::S_FR_RD;
            end

            // fetch front and back for the result
            kopq_pkg::S_FR_RD:
            begin
                if (is_empty)
                begin
                    front_next = '0;
                    back_next  = '0;
                    state_next = kopq_pkg::S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg;
                    state_next = kopq_pkg::S_FR_TAKE;
                end
            end

            kopq_pkg::S_FR_TAKE:
            begin
                front_next = rd_entry;
                rd_en      = 1'b1;
                rd_addr    = phys(head_reg, count_reg - 1'b1);
                state_next = kopq_pkg::S_BK_TAKE;
            end

            kopq_pkg::S_BK_TAKE:
            begin
                back_next  = rd_entry;
                state_next = kopq_pkg::S_DONE;
            end

            kopq_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = {back_reg.key, front_reg.key, back_reg.id,
                                      front_reg.id, is_empty, removed_reg, status_reg};
                    out_valid_next = 1'b1;
                    state_next     = kopq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = kopq_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    `KOPQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH),
                     "entry count exceeds depth")
    `KOPQ_ASSERT_NXT(a_accept_busy, s_axis_tvalid && s_axis_tready,
                     state_reg != kopq_pkg::S_IDLE, "accepted item did not start work")
    `KOPQ_ASSERT_IMP(a_shift_range, state_reg == kopq_pkg::S_SH_RD,
                     idx_reg >= pos_reg && idx_reg <= count_reg,
                     "shift index outside insert window")
    `KOPQ_ASSERT_NXT(a_shift_count, state_reg == kopq_pkg::S_SH_WR,
                     count_reg == $past(count_reg), "count moved during tail shift")
    `KOPQ_ASSERT_IMP(a_empty_status, out_valid_reg && out_data_reg[1:0] == kopq_pkg::ST_EMPTY,
                     out_data_reg[9], "empty status without empty flag")

endmodule
